// ----- sv/velocity_to_rgb_color_unit_assert.svh -----
// Assertion macros of the velocity-to-color checker
`ifndef VELOCITY_TO_RGB_COLOR_UNIT_ASSERT_SVH
`define VELOCITY_TO_RGB_COLOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define VRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("velocity_to_rgb_color_unit: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define VRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("velocity_to_rgb_color_unit: next-cycle check failed");

`endif

// ----- sv/vrc_pkg.sv -----
// Shared widths, constants and word types of the velocity-to-color unit
package vrc_pkg;

    // Velocity field width (Q.12 fixed point, two's complement)
    localparam int VEL_W      = 16;
    // Sum of squares and root datapath
    localparam int SQ_W       = 2 * VEL_W;
    // Channel accumulator in units of 2^-28
    localparam int ACC_W      = VEL_W + 19;
    // Gain register
    localparam int GAIN_W     = 10;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(300);
    // Product of accumulator and zero-extended gain
    localparam int PROD_W     = ACC_W + GAIN_W + 1;
    // sqrt(3)/2 as unsigned Q0.16
    localparam int K_W        = 17;
    localparam logic [K_W-2:0] SQRT3_HALF_Q16 = 16'd56756;
    // Output scaling: add half, drop 29 bits
    localparam int ROUND_POS  = 28;
    localparam int SHIFT      = 29;
    localparam int BYTE_W     = 8;
    // Register stages from input to output word
    localparam int PIPE_DEPTH = VEL_W + 6;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } t_vel_word;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_rgb_word;

endpackage

// ----- sv/vrc_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, velocity word carried alongside
module vrc_isqrt
    import vrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SQ_W-1:0]   i_sq,
    input  t_vel_word         i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [VEL_W-1:0]  o_len,
    output t_vel_word         o_word
);

    localparam int N = VEL_W;

    logic            r_v    [N];
    logic [SQ_W-1:0] r_rem  [N];
    logic [SQ_W-1:0] r_res  [N];
    t_vel_word       r_word [N];
    logic            w_rdy  [N+1];

    // the output side closes the ready chain
    assign w_rdy[N] = i_ready;

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (N - 1 - k));

        logic            v_in;
        logic [SQ_W-1:0] rem_in;
        logic [SQ_W-1:0] res_in;
        t_vel_word       word_in;
        logic [SQ_W:0]   trial;
        logic [SQ_W-1:0] n_rem;
        logic [SQ_W-1:0] n_res;

        if (k == 0) begin : g_head
            assign v_in    = i_valid;
            assign rem_in  = i_sq;
            assign res_in  = '0;
            assign word_in = i_word;
        end else begin : g_body
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign res_in  = r_res[k-1];
            assign word_in = r_word[k-1];
        end

        // a stage takes a new word when empty or when its own word moves on
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        // try to set this root bit
        always_comb begin
            trial = {1'b0, res_in} + {1'b0, BIT};
            if ({1'b0, rem_in} >= trial) begin
                n_rem = rem_in - trial[SQ_W-1:0];
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_rem = rem_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem[k]  <= n_rem;
                r_res[k]  <= n_res;
                r_word[k] <= word_in;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[N-1];
    assign o_len   = r_res[N-1][VEL_W-1:0];
    assign o_word  = r_word[N-1];

endmodule

// ----- sv/vrc_chan.sv -----
// Channel arithmetic: rotate terms, accumulate, scale by gain, round and saturate
module vrc_chan
    import vrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [VEL_W-1:0]  i_len,
    input  t_vel_word         i_word,
    input  logic [GAIN_W-1:0] i_gain,
    output logic              o_valid,
    input  logic              i_ready,
    output t_rgb_word         o_rgb
);

    // round half up, drop the fraction, clamp to a byte
    function automatic logic [BYTE_W-1:0] f_to_byte(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        logic [BYTE_W-1:0]        q;
        t = p + (PROD_W'(1) <<< ROUND_POS);
        if (t < 0) begin
            q = '0;
        end else if (t >= (PROD_W'(256) <<< SHIFT)) begin
            q = '1;
        end else begin
            q = t[SHIFT+BYTE_W-1:SHIFT];
        end
        return q;
    endfunction

    logic r_v_a, r_v_b, r_v_c, r_v_d;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;

    logic signed [VEL_W+K_W-1:0] n_kx, r_kx;
    logic signed [VEL_W+2:0]     n_gc, r_gc;
    logic signed [VEL_W+1:0]     n_rr, r_rr;

    logic signed [ACC_W-1:0]     n_acc_r, n_acc_g, n_acc_b;
    logic signed [ACC_W-1:0]     r_acc_r, r_acc_g, r_acc_b;

    logic signed [PROD_W-1:0]    w_gain_s;
    logic signed [PROD_W-1:0]    n_p_r, n_p_g, n_p_b;
    logic signed [PROD_W-1:0]    r_p_r, r_p_g, r_p_b;

    t_vel_word n_unused_word;
    t_rgb_word n_rgb, r_rgb;

    // ready chain, output end first
    assign w_rdy_d = !r_v_d || i_ready;
    assign w_rdy_c = !r_v_c || w_rdy_d;
    assign w_rdy_b = !r_v_b || w_rdy_c;
    assign w_rdy_a = !r_v_a || w_rdy_b;
    assign o_ready = w_rdy_a;

    // stage A: K*ux, 2*len - uy and uy + len (uy = -vel_y)
    assign n_unused_word = i_word;
    assign n_kx = (VEL_W+K_W)'(n_unused_word.vel_x)
                * (VEL_W+K_W)'($signed({1'b0, SQRT3_HALF_Q16}));
    assign n_gc = $signed({2'b00, i_len, 1'b0}) + (VEL_W+3)'(n_unused_word.vel_y);
    assign n_rr = $signed({2'b00, i_len}) - (VEL_W+2)'(n_unused_word.vel_y);

    // stage B: channel sums in units of 2^-28
    assign n_acc_r = ACC_W'(r_rr) <<< 16;
    assign n_acc_g = (ACC_W'(r_gc) <<< 15) + ACC_W'(r_kx);
    assign n_acc_b = (ACC_W'(r_gc) <<< 15) - ACC_W'(r_kx);

    // stage C: scale by gain
    assign w_gain_s = $signed({{(PROD_W-GAIN_W){1'b0}}, i_gain});
    assign n_p_r = PROD_W'(r_acc_r) * w_gain_s;
    assign n_p_g = PROD_W'(r_acc_g) * w_gain_s;
    assign n_p_b = PROD_W'(r_acc_b) * w_gain_s;

    // stage D: bytes
    assign n_rgb.red   = f_to_byte(r_p_r);
    assign n_rgb.green = f_to_byte(r_p_g);
    assign n_rgb.blue  = f_to_byte(r_p_b);

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else begin
            if (w_rdy_a) r_v_a <= i_valid;
            if (w_rdy_b) r_v_b <= r_v_a;
            if (w_rdy_c) r_v_c <= r_v_b;
            if (w_rdy_d) r_v_d <= r_v_c;
        end
    end

    // advance payload, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_kx <= n_kx;
            r_gc <= n_gc;
            r_rr <= n_rr;
        end
        if (w_rdy_b) begin
            r_acc_r <= n_acc_r;
            r_acc_g <= n_acc_g;
            r_acc_b <= n_acc_b;
        end
        if (w_rdy_c) begin
            r_p_r <= n_p_r;
            r_p_g <= n_p_g;
            r_p_b <= n_p_b;
        end
        if (w_rdy_d) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_v_d;
    assign o_rgb   = r_rgb;

endmodule

// ----- sv/velocity_to_rgb_color_unit.sv -----
// Top level of the velocity-to-color unit: input stages, root pipeline, channel stages
//
// Maps one velocity word (vel_x, vel_y, signed Q3.12) to one RGB word. From
// input to output, two stages square and add, then the square root resolves
// one bit per stage over VEL_W stages, then four stages form, scale, round and
// clamp the three channels. Every stage holds its word while the output is
// stalled, and a new word enters whenever the first stage is free, so while the
// output is not stalled the sustained rate is one word per clock. color_gain is
// written through the configuration channel, which is always ready; write it
// only while no word is in flight.
module velocity_to_rgb_color_unit
    import vrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_vel_word         i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_rgb_word         o_out_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [GAIN_W-1:0] i_cfg_data
);

    logic [GAIN_W-1:0] r_color_gain;

    logic              r_v1, r_v2;
    logic              w_rdy1, w_rdy2;
    t_vel_word         r_w1, r_w2;
    logic signed [SQ_W-1:0] n_sx, n_sy;
    logic [SQ_W-1:0]   r_sx, r_sy;
    logic [SQ_W-1:0]   n_sq, r_sq;

    logic              w_root_ready;
    logic              w_root_valid;
    logic [VEL_W-1:0]  w_len;
    t_vel_word         w_root_word;
    logic              w_chan_ready;

    // gain register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_gain <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_color_gain <= i_cfg_data;
        end
    end

    // ready chain of the input stages
    assign w_rdy2     = !r_v2 || w_root_ready;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    // square both components; the sign of vel_y does not matter here
    assign n_sx = SQ_W'(i_in_word.vel_x) * SQ_W'(i_in_word.vel_x);
    assign n_sy = SQ_W'(i_in_word.vel_y) * SQ_W'(i_in_word.vel_y);
    assign n_sq = r_sx + r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_w1 <= i_in_word;
        end
        if (w_rdy2) begin
            r_sq <= n_sq;
            r_w2 <= r_w1;
        end
    end

    vrc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .o_ready (w_root_ready),
        .i_sq    (r_sq),
        .i_word  (r_w2),
        .o_valid (w_root_valid),
        .i_ready (w_chan_ready),
        .o_len   (w_len),
        .o_word  (w_root_word)
    );

    vrc_chan u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_root_valid),
        .o_ready (w_chan_ready),
        .i_len   (w_len),
        .i_word  (w_root_word),
        .i_gain  (r_color_gain),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rgb   (o_out_word)
    );

endmodule

// ----- sv/vrc_checker.sv -----
// Port-level checks of the velocity-to-color unit and their bind
`include "velocity_to_rgb_color_unit_assert.svh"

module vrc_checker
    import vrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  t_rgb_word         o_out_word
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    logic [CNT_W-1:0] r_cnt;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // track words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (w_out_acc && !w_in_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // a stalled output word holds
    `VRC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word))
    // no output word without one in flight
    `VRC_ASSERT_NOW(a_out_has_src, o_out_valid, r_cnt != '0)
    // the pipeline never holds more words than it has stages
    `VRC_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(PIPE_DEPTH))
    // input back-pressure only comes from a stalled, full output
    `VRC_ASSERT_NOW(a_stall_origin, !o_in_ready, o_out_valid && !i_out_ready)

endmodule

bind velocity_to_rgb_color_unit vrc_checker u_vrc_checker (.*);
